@@ sv/queue_with_positional_insert_core_assert.svh @@
// Assertion macros for the positional insert queue.
// Included by the RTL files that assert; uses the clk and rst of the including module.
`ifndef QUEUE_WITH_POSITIONAL_INSERT_CORE_ASSERT_SVH
`define QUEUE_WITH_POSITIONAL_INSERT_CORE_ASSERT_SVH

// same-cycle implication
`define QPI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue core check failed");

// next-cycle implication
`define QPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue core check failed");

`endif

@@ sv/qpi_pkg.sv @@
// Shared types and constants for the positional insert queue.
// No dependencies; imported by qpi_cell and the top level.
`default_nettype none

package qpi_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int AHEAD_W    = 5;
  localparam int CMP_W      = (CNT_W > AHEAD_W) ? CNT_W : AHEAD_W;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_t;

  // broadcast to every cell for one word
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } qpi_ctrl_t;

endpackage

`default_nettype wire

@@ sv/qpi_cell.sv @@
// One storage slot of the queue chain: holds, loads or shifts from a neighbour.
// Depends on qpi_pkg.
`default_nettype none

module qpi_cell import qpi_pkg::*; (
  input  wire                  clk,
  input  wire qpi_ctrl_t       ctrl,
  input  wire [IDX_W-1:0]      index,
  input  wire [WORD_WIDTH-1:0] new_word,
  input  wire [WORD_WIDTH-1:0] prev_word,
  input  wire [WORD_WIDTH-1:0] next_word,
  output logic [WORD_WIDTH-1:0] word
);

  cell_op_t         sel;
  logic [CNT_W-1:0] idx;
  logic [CNT_W:0]   idx_inc;

  assign idx     = CNT_W'(index);
  assign idx_inc = {1'b0, idx} + (CNT_W + 1)'(1);

  always_comb begin
    sel = CELL_HOLD;
    if (ctrl.enq) begin
      if (idx == ctrl.pos) begin
        sel = CELL_LOAD;
      end else if ((idx > ctrl.pos) && (idx <= ctrl.count)) begin
        sel = CELL_FROM_PREV;
      end
    end else if (ctrl.deq) begin
      if (idx_inc < {1'b0, ctrl.count}) begin
        sel = CELL_FROM_NEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (sel)
      CELL_LOAD:      word <= new_word;
      CELL_FROM_PREV: word <= prev_word;
      CELL_FROM_NEXT: word <= next_word;
      default:        word <= word;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/queue_with_positional_insert_core.sv @@
// Bounded queue of DEPTH words with insertion a chosen number of places ahead of the tail.
// Top level; depends on qpi_pkg, qpi_cell and queue_with_positional_insert_core_assert.svh.
//
// A bounded FIFO of DEPTH words held in a row of qpi_cell slots, slot 0 the head.
// Each input word is either an enqueue (s_tuser = 0) carrying a data word and a
// places_ahead value p, or a dequeue (s_tuser = 1). An enqueue with p = 0 appends at
// the tail; with p below the fill count the word lands p slots short of the tail and
// the p youngest words step one slot tailwards; with p at or beyond the count it
// becomes the head. A dequeue returns the head and each slot below the new count takes
// its successor's word. Every input word yields exactly one result word: the removed
// word with head_valid set, the fill count after the operation, and a status (ok, enqueue
// dropped when full, dequeue on empty). One word is taken per clock cycle: all slots
// decide locally and update in the same edge, and the result sits in a single output
// register, so outside reset s_tready stays high while m_tready is high or no result
// is pending. m_tvalid rises in the cycle after acceptance. Slot contents are not
// reset; only slots below the fill count are ever read.
`default_nettype none

`include "queue_with_positional_insert_core_assert.svh"

module queue_with_positional_insert_core import qpi_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,  // [31:0] data_word, [36:32] places_ahead, [39:37] zero
  input  wire  [0:0]  s_tuser,  // [0] action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,  // [31:0] head_word, [36:32] fill_count, [39:37] zero
  output logic [2:0]  m_tuser   // [0] head_valid, [2:1] status
);

  // ---- input word unpacking
  logic                  accept;
  logic                  action;
  logic [31:0]           data_word;
  logic [AHEAD_W-1:0]    places_ahead;

  assign accept       = s_tvalid && s_tready;
  assign action       = s_tuser[0];
  assign data_word    = s_tdata[31:0];
  assign places_ahead = s_tdata[36:32];

  // ---- fill count and control
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] ahead_w;
  logic [CMP_W-1:0] count_w;
  logic [CNT_W-1:0] pos;
  qpi_ctrl_t        ctrl;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign ahead_w = CMP_W'(places_ahead);
  assign count_w = CMP_W'(count);
  // insert point counted from the head; saturates at the head
  assign pos     = (ahead_w >= count_w) ? '0 : CNT_W'(count_w - ahead_w);

  assign ctrl.enq   = accept && (action == ACT_ENQ) && !full;
  assign ctrl.deq   = accept && (action == ACT_DEQ) && !empty;
  assign ctrl.pos   = pos;
  assign ctrl.count = count;

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // ---- slot chain
  logic [WORD_WIDTH-1:0] cell_word [DEPTH];
  logic [WORD_WIDTH-1:0] new_word;

  assign new_word = WORD_WIDTH'(data_word);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] prev_word;
    logic [WORD_WIDTH-1:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = '0;
    end else begin : g_mid_prev
      assign prev_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = '0;
    end else begin : g_mid_next
      assign next_word = cell_word[i+1];
    end

    qpi_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .index     (IDX_W'(i)),
      .new_word  (new_word),
      .prev_word (prev_word),
      .next_word (next_word),
      .word      (cell_word[i])
    );
  end

  // ---- result word
  status_t     res_status;
  logic        res_valid;
  logic [31:0] res_word;

  always_comb begin
    res_status = ST_OK;
    res_valid  = 1'b0;
    res_word   = '0;
    if (action == ACT_ENQ) begin
      if (full) begin
        res_status = ST_FULL;
      end
    end else begin
      if (empty) begin
        res_status = ST_EMPTY;
      end else begin
        res_valid = 1'b1;
        res_word  = 32'(cell_word[0]);
      end
    end
  end

  // single output register; a new word is taken whenever it drains
  assign s_tready = !rst && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, 5'(count_next), res_word};
      m_tuser <= {res_status, res_valid};
    end
  end

  // ---- checks
  `QPI_ASSERT_NEXT(a_enq_grows, ctrl.enq, count == $past(count) + CNT_W'(1))
  `QPI_ASSERT_NEXT(a_deq_shrinks, ctrl.deq, count == $past(count) - CNT_W'(1))
  `QPI_ASSERT_NEXT(a_deq_flags_word, ctrl.deq, m_tvalid && m_tuser[0])
  `QPI_ASSERT_IMPL(a_full_status, m_tvalid && (m_tuser[2:1] == ST_FULL),
                   m_tdata[36:32] == 5'(DEPTH))

endmodule

`default_nettype wire
